/* hdl/ssror_pkg.sv */
// Shared types and constants for the short-run outlier removal block.
package ssror_pkg;

    localparam int GAP_W      = 16;
    localparam int MIN_RUN_W  = 4;
    localparam int PASS_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [GAP_W-1:0]     GAP_RESET     = 16'd300;
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_RESET = 4'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_DISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN      = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_READ,
        ST_HELD,
        ST_CUR
    } t_state;

    typedef struct packed {
        logic done;
        logic far;
    } t_gap_res;

endpackage

/* hdl/ssror_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ssror_ram #(
    parameter int  WIDTH = 72,
    parameter int  DEPTH = 7,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ssror_gap.sv */
// Squared neighbour distance against squared gap setting, two register stages.
module ssror_gap
    import ssror_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_prev_x,
    input  logic signed [COORD_BITS-1:0] i_prev_y,
    input  logic [GAP_W-1:0]             i_gap,
    output t_gap_res                     o_res
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = (2 * COORD_BITS + 1 > 2 * GAP_W) ? 2 * COORD_BITS + 1 : 2 * GAP_W;

    logic signed [DW-1:0] diff_x, diff_y;
    logic [DW-1:0]        mag_x, mag_y;

    logic                    r_v1, r_v2;
    logic [COORD_BITS-1:0]   r_dx, r_dy;
    logic [GAP_W-1:0]        r_gap_q;
    logic [2*COORD_BITS-1:0] r_dx2, r_dy2;
    logic [2*GAP_W-1:0]      r_g2;
    logic [SW-1:0]           sum_ext, g2_ext;

    // The difference of two coordinates always has a magnitude below 2**COORD_BITS
    assign diff_x = {i_x[COORD_BITS-1], i_x} - {i_prev_x[COORD_BITS-1], i_prev_x};
    assign diff_y = {i_y[COORD_BITS-1], i_y} - {i_prev_y[COORD_BITS-1], i_prev_y};
    assign mag_x  = diff_x[DW-1] ? (~diff_x + DW'(1)) : diff_x;
    assign mag_y  = diff_y[DW-1] ? (~diff_y + DW'(1)) : diff_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        if (i_start) begin
            r_dx    <= mag_x[COORD_BITS-1:0];
            r_dy    <= mag_y[COORD_BITS-1:0];
            r_gap_q <= i_gap;
        end
        if (r_v1) begin
            r_dx2 <= r_dx * r_dx;
            r_dy2 <= r_dy * r_dy;
            r_g2  <= r_gap_q * r_gap_q;
        end
    end

    assign sum_ext = SW'(r_dx2) + SW'(r_dy2);
    assign g2_ext  = SW'(r_g2);

    assign o_res.done = r_v2;
    assign o_res.far  = sum_ext > g2_ext;

endmodule

/* hdl/scan_short_run_outlier_removal.sv */
// A point is registered on acceptance and then passes the register stages of the
// distance unit; no new point is taken until the block is back in ST_IDLE. Releasing
// a run with k held points reads each one from the hold RAM and loads it into the
// output register as the output slot frees, then loads the current point.
// Reset is synchronous: control state and configuration return to their defaults;
// the hold RAM is not cleared, entries are read only after being written.
module scan_short_run_outlier_removal
    import ssror_pkg::*;
#(
    parameter int MAX_MIN_RUN = 8,
    parameter int COORD_BITS  = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic [PASS_W-1:0]            i_point_range,
    input  logic [PASS_W-1:0]            i_point_angle,
    input  logic                         i_end_of_scan,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic [PASS_W-1:0]            o_out_range,
    output logic [PASS_W-1:0]            o_out_angle,
    output logic                         o_burst_last
);
    localparam int HOLD_DEPTH = MAX_MIN_RUN - 1;
    localparam int ADDR_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MAX_MIN_RUN);
    localparam int CMP_W      = ((CNT_W > MIN_RUN_W) ? CNT_W : MIN_RUN_W) + 1;
    localparam int PT_W       = 2 * COORD_BITS + 2 * PASS_W;

    t_state r_state, n_state;

    logic [GAP_W-1:0]      r_gap;
    logic [MIN_RUN_W-1:0]  r_min_run;

    logic                  r_have_prev, n_have_prev;
    logic [COORD_BITS-1:0] r_prev_x, n_prev_x;
    logic [COORD_BITS-1:0] r_prev_y, n_prev_y;
    logic [CNT_W-1:0]      r_run_cnt, n_run_cnt;
    logic                  r_released, n_released;
    logic [CNT_W-1:0]      r_fcnt, n_fcnt;
    logic [CNT_W-1:0]      r_idx, n_idx;

    logic [COORD_BITS-1:0] r_pt_x, r_pt_y;
    logic [PASS_W-1:0]     r_pt_range, r_pt_angle;
    logic                  r_eos;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [PASS_W-1:0]     r_out_range, r_out_angle;
    logic                  r_out_last;

    logic in_accept, slot_free, load_held, load_cur, ram_we, ram_re;
    logic new_run, rel_eff, release_now;
    logic [CNT_W-1:0] cnt_eff, idx_inc;
    logic [CMP_W-1:0] mr_ext, m_eff, cnt_ext;
    logic [PT_W-1:0]  ram_wdata, ram_rdata;
    t_gap_res         gap_res;

    assign in_accept = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;

    ssror_gap #(
        .COORD_BITS(COORD_BITS)
    ) u_gap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_x      (i_point_x),
        .i_y      (i_point_y),
        .i_prev_x (r_prev_x),
        .i_prev_y (r_prev_y),
        .i_gap    (r_gap),
        .o_res    (gap_res)
    );

    assign ram_wdata = {r_pt_x, r_pt_y, r_pt_range, r_pt_angle};

    // Write address uses the count before advance, so drive it from the effective count
    // when a new run restarts the hold buffer.
    ssror_ram #(
        .WIDTH(PT_W),
        .DEPTH(HOLD_DEPTH)
    ) u_hold (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_eff[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Effective run limit: zero counts as one, clamp to MAX_MIN_RUN (hold depth plus one)
    always_comb begin
        mr_ext = CMP_W'(r_min_run);
        if (mr_ext == '0) begin
            m_eff = CMP_W'(1);
        end else if (mr_ext > CMP_W'(MAX_MIN_RUN)) begin
            m_eff = CMP_W'(MAX_MIN_RUN);
        end else begin
            m_eff = mr_ext;
        end
    end

    assign new_run     = r_have_prev && gap_res.far;
    assign cnt_eff     = new_run ? '0 : r_run_cnt;
    assign rel_eff     = new_run ? 1'b0 : r_released;
    assign cnt_ext     = CMP_W'(cnt_eff);
    assign release_now = (cnt_ext + CMP_W'(1)) >= m_eff;
    assign idx_inc     = r_idx + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_run_cnt   = r_run_cnt;
        n_released  = r_released;
        n_fcnt      = r_fcnt;
        n_idx       = r_idx;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load_held   = 1'b0;
        load_cur    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_GAP;
                end
            end
            ST_GAP: begin
                if (gap_res.done) begin
                    if (rel_eff) begin
                        n_run_cnt  = cnt_eff;
                        n_released = 1'b1;
                        n_state    = ST_CUR;
                    end else if (release_now) begin
                        n_fcnt     = cnt_eff;
                        n_idx      = '0;
                        n_run_cnt  = '0;
                        n_released = 1'b1;
                        n_state    = (cnt_eff == '0) ? ST_CUR : ST_READ;
                    end else begin
                        n_released = 1'b0;
                        n_run_cnt  = cnt_eff;
                        if (cnt_eff < CNT_W'(HOLD_DEPTH)) begin
                            // hold the point; write address is the count before it advances
                            ram_we    = 1'b1;
                            n_run_cnt = cnt_eff + CNT_W'(1);
                        end
                        n_state = ST_IDLE;
                    end
                    n_have_prev = 1'b1;
                    n_prev_x    = r_pt_x;
                    n_prev_y    = r_pt_y;
                    if (r_eos) begin
                        n_have_prev = 1'b0;
                        n_prev_x    = '0;
                        n_prev_y    = '0;
                        n_run_cnt   = '0;
                        n_released  = 1'b0;
                    end
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_HELD;
            end
            ST_HELD: begin
                if (slot_free) begin
                    load_held = 1'b1;
                    n_idx     = idx_inc;
                    n_state   = (idx_inc == r_fcnt) ? ST_CUR : ST_READ;
                end
            end
            ST_CUR: begin
                if (slot_free) begin
                    load_cur = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gap       <= GAP_RESET;
            r_min_run   <= MIN_RUN_RESET;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_run_cnt   <= '0;
            r_released  <= 1'b0;
            r_fcnt      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_run_cnt   <= n_run_cnt;
            r_released  <= n_released;
            r_fcnt      <= n_fcnt;
            r_idx       <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAP_DISTANCE: r_gap     <= i_cfg_wdata[GAP_W-1:0];
                    CFG_MIN_RUN:      r_min_run <= i_cfg_wdata[MIN_RUN_W-1:0];
                    default: ;
                endcase
            end
            if (load_held || load_cur) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_accept) begin
            r_pt_x     <= i_point_x;
            r_pt_y     <= i_point_y;
            r_pt_range <= i_point_range;
            r_pt_angle <= i_point_angle;
            r_eos      <= i_end_of_scan;
        end
        if (load_held) begin
            {r_out_x, r_out_y, r_out_range, r_out_angle} <= ram_rdata;
            r_out_last <= 1'b0;
        end else if (load_cur) begin
            r_out_x     <= r_pt_x;
            r_out_y     <= r_pt_y;
            r_out_range <= r_pt_range;
            r_out_angle <= r_pt_angle;
            r_out_last  <= 1'b1;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_out_range  = r_out_range;
    assign o_out_angle  = r_out_angle;
    assign o_burst_last = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt <= CNT_W'(HOLD_DEPTH))
        else $error("hold count beyond hold depth");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_HELD) |-> (r_idx < r_fcnt))
        else $error("flush index past flush count");

    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GAP && gap_res.done && r_eos) |=> (!r_have_prev && r_run_cnt == '0))
        else $error("scan state not cleared after end of scan");

    a_gap_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gap_res.done |-> (r_state == ST_GAP))
        else $error("distance result outside wait state");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_HELD || r_state == ST_CUR))
        else $error("output loaded outside emit states");

endmodule

/* tb/sv/ssror_run_checker.sv */
// Checker for the short-run outlier removal block: predicts kept points and compares them.
module ssror_run_checker
    import ssror_pkg::*;
#(
    parameter int MAX_MIN_RUN = 8,
    parameter int COORD_BITS  = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic [PASS_W-1:0]            i_point_range,
    input  logic [PASS_W-1:0]            i_point_angle,
    input  logic                         i_end_of_scan,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic signed [COORD_BITS-1:0] i_out_x,
    input  logic signed [COORD_BITS-1:0] i_out_y,
    input  logic [PASS_W-1:0]            i_out_range,
    input  logic [PASS_W-1:0]            i_out_angle,
    input  logic                         i_burst_last,
    output int                           o_errors,
    output int                           o_pending
);

    localparam int HOLD_DEPTH = MAX_MIN_RUN - 1;
    localparam int PRINT_CAP  = 40;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord            x;
        t_coord            y;
        logic [PASS_W-1:0] rng;
        logic [PASS_W-1:0] ang;
        logic              last;
    } t_kept_point;

    logic [GAP_W-1:0]     gap_distance;
    logic [MIN_RUN_W-1:0] min_run;

    logic   have_prev;
    t_coord prev_x;
    t_coord prev_y;
    int     run_count;
    logic   released;

    t_coord            held_x     [HOLD_DEPTH];
    t_coord            held_y     [HOLD_DEPTH];
    logic [PASS_W-1:0] held_range [HOLD_DEPTH];
    logic [PASS_W-1:0] held_angle [HOLD_DEPTH];

    t_kept_point kept_q[$];
    int          errors  = 0;
    int          pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;

    task automatic report(input string what);
        errors++;
        // keep the log short when the block is badly broken; every mismatch still counts
        if (errors <= PRINT_CAP) begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    task automatic clear_scan();
        have_prev = 1'b0;
        prev_x    = '0;
        prev_y    = '0;
        run_count = 0;
        released  = 1'b0;
    endtask

    task automatic push_kept(input t_coord x, input t_coord y,
                             input logic [PASS_W-1:0] rng, input logic [PASS_W-1:0] ang);
        kept_q.push_back('{x, y, rng, ang, 1'b0});
    endtask

    task automatic predict_point(input t_coord x, input t_coord y,
                                 input logic [PASS_W-1:0] rng, input logic [PASS_W-1:0] ang,
                                 input logic eos);
        longint dx;
        longint dy;
        int     limit;
        int     size_before;
        limit = (min_run == 0) ? 1 : (min_run > MAX_MIN_RUN) ? MAX_MIN_RUN : int'(min_run);
        size_before = kept_q.size();

        // exact squared distance against squared gap
        if (have_prev) begin
            dx = longint'(x) - longint'(prev_x);
            dy = longint'(y) - longint'(prev_y);
            if (dx * dx + dy * dy > longint'(gap_distance) * longint'(gap_distance)) begin
                run_count = 0;
                released  = 1'b0;
            end
        end

        if (released) begin
            push_kept(x, y, rng, ang);
        end else if (run_count + 1 >= limit) begin
            for (int i = 0; i < run_count && i < HOLD_DEPTH; i++) begin
                push_kept(held_x[i], held_y[i], held_range[i], held_angle[i]);
            end
            push_kept(x, y, rng, ang);
            run_count = 0;
            released  = 1'b1;
        end else if (run_count < HOLD_DEPTH) begin
            held_x[run_count]     = x;
            held_y[run_count]     = y;
            held_range[run_count] = rng;
            held_angle[run_count] = ang;
            run_count++;
        end

        if (kept_q.size() > size_before) begin
            kept_q[kept_q.size() - 1].last = 1'b1;
        end

        prev_x    = x;
        prev_y    = y;
        have_prev = 1'b1;
        if (eos) begin
            clear_scan();
        end
    endtask

    task automatic check_kept();
        t_kept_point want;
        if (kept_q.size() == 0) begin
            report($sformatf("point (%0d, %0d) range %0d with none expected",
                             i_out_x, i_out_y, i_out_range));
            return;
        end
        want = kept_q.pop_front();
        if (i_out_x !== want.x) begin
            report($sformatf("out_x %0d, expected %0d", i_out_x, want.x));
        end
        if (i_out_y !== want.y) begin
            report($sformatf("out_y %0d, expected %0d", i_out_y, want.y));
        end
        if (i_out_range !== want.rng) begin
            report($sformatf("out_range %0d, expected %0d", i_out_range, want.rng));
        end
        if (i_out_angle !== want.ang) begin
            report($sformatf("out_angle %0d, expected %0d", i_out_angle, want.ang));
        end
        if (i_burst_last !== want.last) begin
            report($sformatf("burst_last %b, expected %b", i_burst_last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_distance = GAP_RESET;
            min_run      = MIN_RUN_RESET;
            clear_scan();
            kept_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_GAP_DISTANCE) begin
                    gap_distance = i_cfg_wdata[GAP_W-1:0];
                end else if (i_cfg_index == CFG_MIN_RUN) begin
                    min_run = i_cfg_wdata[MIN_RUN_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_point(i_point_x, i_point_y, i_point_range, i_point_angle,
                              i_end_of_scan);
            end
            if (i_out_valid && !i_out_stall) begin
                check_kept();
            end
        end
        pending = kept_q.size();
    end

endmodule

/* tb/sv/scan_short_run_outlier_removal_tb.sv */
// Top of the testbench: clock, reset, point stimulus, output back-pressure and the verdict.
module scan_short_run_outlier_removal_tb
    import ssror_pkg::*;
();

    localparam int COORD_BITS      = 20;
    localparam int MAX_MIN_RUN     = 8;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_POINTS    = 55;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_GAP_DISTANCE;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    t_coord                point_x     = '0;
    t_coord                point_y     = '0;
    logic [PASS_W-1:0]     point_range = '0;
    logic [PASS_W-1:0]     point_angle = '0;
    logic                  end_of_scan = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    t_coord                out_x;
    t_coord                out_y;
    logic [PASS_W-1:0]     out_range;
    logic [PASS_W-1:0]     out_angle;
    logic                  burst_last;

    int errors;
    int pending;

    bit               idling_on    = 1'b1;
    bit               hold_request = 1'b0;
    bit               hold_done    = 1'b0;
    int               quiet_cycles = 0;
    t_coord           last_x       = '0;
    t_coord           last_y       = '0;
    logic [GAP_W-1:0] cur_gap      = GAP_RESET;

    logic [GAP_W-1:0]     phase_gap [RANDOM_PHASES];
    logic [MIN_RUN_W-1:0] phase_min [RANDOM_PHASES];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    scan_short_run_outlier_removal #(
        .MAX_MIN_RUN (MAX_MIN_RUN),
        .COORD_BITS  (COORD_BITS)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_point_x     (point_x),
        .i_point_y     (point_y),
        .i_point_range (point_range),
        .i_point_angle (point_angle),
        .i_end_of_scan (end_of_scan),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_x       (out_x),
        .o_out_y       (out_y),
        .o_out_range   (out_range),
        .o_out_angle   (out_angle),
        .o_burst_last  (burst_last)
    );

    ssror_run_checker #(
        .MAX_MIN_RUN (MAX_MIN_RUN),
        .COORD_BITS  (COORD_BITS)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_point_x     (point_x),
        .i_point_y     (point_y),
        .i_point_range (point_range),
        .i_point_angle (point_angle),
        .i_end_of_scan (end_of_scan),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_x       (out_x),
        .i_out_y       (out_y),
        .i_out_range   (out_range),
        .i_out_angle   (out_angle),
        .i_burst_last  (burst_last),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // watchdog: end the run if no transaction of any kind happens for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output back-pressure: random bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_request && !hold_done) begin
                out_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                out_stall = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_point(input t_coord x, input t_coord y,
                              input logic [PASS_W-1:0] rng, input logic [PASS_W-1:0] ang,
                              input logic eos);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid    = 1'b1;
        point_x     = x;
        point_y     = y;
        point_range = rng;
        point_angle = ang;
        end_of_scan = eos;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        last_x = x;
        last_y = y;
    endtask

    // write only once the block has drained and any held-point work has settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_GAP_DISTANCE) begin
            cur_gap = data;
        end
    endtask

    // runs of nearby points with random content, broken up by jumps, noise and scan ends
    task automatic random_phase(input int count);
        int     sent;
        int     len;
        int     half;
        int     step_x;
        int     step_y;
        t_coord x;
        t_coord y;
        logic   eos;
        sent = 0;
        half = int'(cur_gap) / 2;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                x   = t_coord'($urandom);
                y   = t_coord'($urandom);
                eos = ($urandom_range(0, 7) == 0);
                send_point(x, y, PASS_W'($urandom), PASS_W'($urandom), eos);
                sent++;
            end else begin
                len = $urandom_range(1, 10);
                // start just past the gap now and then, otherwise anywhere
                if ($urandom_range(0, 5) == 0) begin
                    x = t_coord'(int'(last_x) + int'(cur_gap) + 1);
                    y = last_y;
                end else begin
                    x = t_coord'($urandom);
                    y = t_coord'($urandom);
                end
                for (int k = 0; k < len && sent < count; k++) begin
                    if (k > 0) begin
                        case ($urandom_range(0, 7))
                            0: begin
                                step_x = int'(cur_gap);
                                step_y = 0;
                            end
                            1: begin
                                step_x = 0;
                                step_y = -int'(cur_gap);
                            end
                            default: begin
                                step_x = int'($urandom_range(0, 2 * half)) - half;
                                step_y = int'($urandom_range(0, 2 * half)) - half;
                            end
                        endcase
                        x = t_coord'(int'(last_x) + step_x);
                        y = t_coord'(int'(last_y) + step_y);
                    end
                    eos = (k == len - 1) && ($urandom_range(0, 2) == 0);
                    send_point(x, y, PASS_W'($urandom), PASS_W'($urandom), eos);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] cfg_word;

        phase_gap[0] = 16'hFFFF;                         phase_min[0] = 4'd8;
        phase_gap[1] = 16'd0;                            phase_min[1] = 4'd1;
        phase_gap[2] = 16'd300;                          phase_min[2] = 4'd3;
        phase_gap[3] = GAP_W'($urandom);                 phase_min[3] = 4'd15;
        phase_gap[4] = GAP_W'($urandom_range(50, 1000)); phase_min[4] = 4'd2;
        phase_gap[5] = GAP_W'($urandom_range(50, 1000)); phase_min[5] = 4'd5;
        phase_gap[6] = 16'd1000;                         phase_min[6] = 4'd0;
        phase_gap[7] = GAP_W'($urandom_range(0, 65535));
        phase_min[7] = MIN_RUN_W'($urandom_range(0, 15));

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero gap, every point kept: coordinate and payload extremes, repeated point
        write_reg(CFG_GAP_DISTANCE, 16'd0);
        write_reg(CFG_MIN_RUN, 16'd1);
        send_point(COORD_MIN, COORD_MAX, 16'h0000, 16'hFFFF, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 16'hFFFF, 16'h0000, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 16'h5A5A, 16'hA5A5, 1'b1);

        // widest gap with the largest possible jump; min_run of zero acts as one
        write_reg(CFG_GAP_DISTANCE, 16'hFFFF);
        write_reg(CFG_MIN_RUN, 16'd0);
        send_point(COORD_MIN, COORD_MIN, 16'd1, 16'd2, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 16'd3, 16'd4, 1'b0);

        // exactly at the gap stays in the run, one more splits it; end of scan drops
        // a short run and the next point starts afresh
        write_reg(CFG_MIN_RUN, 16'd3);
        send_point(t_coord'(0), t_coord'(0), 16'd10, 16'd11, 1'b0);
        send_point(t_coord'(65535), t_coord'(0), 16'd12, 16'd13, 1'b0);
        send_point(t_coord'(131071), t_coord'(0), 16'd14, 16'd15, 1'b0);
        send_point(t_coord'(131071), t_coord'(0), 16'd16, 16'd17, 1'b1);
        send_point(t_coord'(131071), t_coord'(0), 16'd18, 16'd19, 1'b0);
        send_point(t_coord'(131071), t_coord'(0), 16'd20, 16'd21, 1'b0);
        send_point(t_coord'(131071), t_coord'(0), 16'd22, 16'd23, 1'b0);

        // min_run above the hold depth clamps; lowering it releases what is held
        write_reg(CFG_GAP_DISTANCE, 16'd300);
        write_reg(CFG_MIN_RUN, 16'd15);
        for (int k = 0; k < 5; k++) begin
            send_point(t_coord'(1000 + 10 * k), t_coord'(-1000 - 10 * k),
                       16'(100 + k), 16'(200 + k), 1'b0);
        end
        write_reg(CFG_MIN_RUN, 16'd2);
        send_point(t_coord'(1050), t_coord'(-1050), 16'd105, 16'd205, 1'b0);

        // longest release: a full hold plus the current point, then end of scan
        write_reg(CFG_MIN_RUN, 16'd8);
        for (int k = 0; k < 8; k++) begin
            send_point(t_coord'(-200000 + 7 * k), t_coord'(300000 - 3 * k),
                       16'(300 + k), 16'(400 + k), k == 7);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) begin
                idling_on = 1'b0;
            end
            write_reg(CFG_GAP_DISTANCE, phase_gap[p]);
            cfg_word      = CFG_DATA_W'($urandom);
            cfg_word[3:0] = phase_min[p];
            write_reg(CFG_MIN_RUN, cfg_word);
            // every point is kept here, so a long hold-off fills the block
            if (p == 1) begin
                hold_request = 1'b1;
            end
            random_phase(PHASE_POINTS);
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* scan_short_run_outlier_removal.f */
hdl/ssror_pkg.sv
hdl/ssror_ram.sv
hdl/ssror_gap.sv
hdl/scan_short_run_outlier_removal.sv
tb/sv/ssror_run_checker.sv
tb/sv/scan_short_run_outlier_removal_tb.sv
